### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or sequence property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

### hw/rtl/cwhc_pkg.sv
// Constants and types for the column window hit counter.
`timescale 1ns / 1ps

package cwhc_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_WINDOW  = 64;

	localparam int COL_W   = $clog2(MAX_COLUMNS);
	localparam int HIST_W  = 64;
	localparam int WIN_W   = 7;
	localparam int GRP_W   = 8;
	localparam int GROUPS  = HIST_W / GRP_W;
	localparam int GCNT_W  = $clog2(GRP_W + 1);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);
	localparam logic [WIN_W-1:0] WIN_MAX  = WIN_W'(MAX_WINDOW);

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [HIST_W-1:0] hist_t;
	typedef logic [WIN_W-1:0]  count_t;
	typedef logic [GCNT_W-1:0] gcnt_t;

endpackage

### hw/rtl/column_window_hit_counter.sv
// Top level of the column window hit counter: history RAM and its read-modify-write pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | hit, matrix_start, row_end
//  out     | out_valid / out_ready| window_count, row_done
//  cfg     | cfg_valid / cfg_ready| cfg_data (window_rows)
//
// One cell per cycle sustained while out_ready stays high; a result passes stage 1, stage 2 and the output register.
// The rate is set by the single read port and single write port of the column history RAM;
// a cell that hits the column its predecessor is writing gets the new history by forwarding.
// Reset clears the column position, the first-row flag, the window (to one row) and all
// valid bits; the history RAM is not cleared, first-row cells ignore what they read.
// Stalls on out back up stage by stage; in_ready drops only when stage 1 is held.

module column_window_hit_counter (
	input  logic                    clk,
	input  logic                    arst_n,
	// input cells
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    hit,
	input  logic                    matrix_start,
	input  logic                    row_end,
	// results
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [cwhc_pkg::WIN_W-1:0] window_count,
	output logic                    row_done,
	// window register
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [cwhc_pkg::WIN_W-1:0] cfg_data
);

	// ---------------------------------------------------------------
	// Window mask register: bit i set when row i back lies in the window.
	// Saturate the window at MAX_WINDOW before building the mask.
	// ---------------------------------------------------------------
	cwhc_pkg::hist_t  win_mask_q;
	cwhc_pkg::hist_t  win_mask_d;
	cwhc_pkg::count_t win_sat;

	always_comb begin
		win_sat = (cfg_data > cwhc_pkg::WIN_MAX) ? cwhc_pkg::WIN_MAX : cfg_data;
		for (int i = 0; i < cwhc_pkg::HIST_W; i++) begin
			win_mask_d[i] = (cwhc_pkg::WIN_W'(i) < win_sat);
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_mask_q <= cwhc_pkg::hist_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			win_mask_q <= win_mask_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: track the column and the first-row flag, issue the RAM read.
	// ---------------------------------------------------------------
	logic            in_accept;
	cwhc_pkg::col_t  col_q;
	logic            first_q;
	cwhc_pkg::col_t  col_cur;
	logic            first_cur;

	// Stage handshake signals, driven further down
	logic            valid_s1;
	logic            valid_s2;
	logic            s1_move;
	logic            s2_free;
	logic            out_load;

	assign in_ready  = !valid_s1 || s1_move;
	assign in_accept = in_valid && in_ready;

	// A new matrix restarts at column zero in its first row
	assign col_cur   = matrix_start ? '0 : col_q;
	assign first_cur = matrix_start || first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (in_accept) begin
			if (row_end) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				// Wrap past the last column
				col_q   <= (col_cur == cwhc_pkg::LAST_COL) ? '0 : col_cur + 1'b1;
				first_q <= first_cur;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: RAM data arrives; merge forwarded history, shift in the hit,
	// write back, and count set bits per group inside the window.
	// ---------------------------------------------------------------
	cwhc_pkg::col_t  col_s1;
	logic            first_s1;
	logic            hit_s1;
	logic            row_end_s1;
	logic            fwd_s1;
	cwhc_pkg::hist_t fwd_hist_s1;
	cwhc_pkg::hist_t rd_hist;
	cwhc_pkg::hist_t old_hist;
	cwhc_pkg::hist_t new_hist;
	cwhc_pkg::hist_t masked_hist;
	cwhc_pkg::gcnt_t grp_cnt [cwhc_pkg::GROUPS];

	cwhc_ram #(
		.WIDTH (cwhc_pkg::HIST_W),
		.DEPTH (cwhc_pkg::MAX_COLUMNS)
	) u_hist_ram (
		.clk   (clk),
		.we    (s1_move),
		.waddr (col_s1),
		.wdata (new_hist),
		.re    (in_accept),
		.raddr (col_cur),
		.rdata (rd_hist)
	);

	assign s1_move = valid_s1 && s2_free;

	always_comb begin
		// Take the forwarded word when the previous cell wrote this column on the read edge
		old_hist    = fwd_s1 ? fwd_hist_s1 : rd_hist;
		// Ignore stale history in the first row of a matrix
		new_hist    = {(first_s1 ? '0 : old_hist[cwhc_pkg::HIST_W-2:0]), hit_s1};
		masked_hist = new_hist & win_mask_q;
		for (int g = 0; g < cwhc_pkg::GROUPS; g++) begin
			grp_cnt[g] = '0;
			for (int b = 0; b < cwhc_pkg::GRP_W; b++) begin
				grp_cnt[g] = grp_cnt[g]
					+ cwhc_pkg::GCNT_W'(masked_hist[g*cwhc_pkg::GRP_W + b]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			col_s1      <= col_cur;
			first_s1    <= first_cur;
			hit_s1      <= hit;
			row_end_s1  <= row_end;
			fwd_s1      <= s1_move && (col_s1 == col_cur);
			fwd_hist_s1 <= new_hist;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: hold the group counts, sum them into the result register.
	// ---------------------------------------------------------------
	cwhc_pkg::gcnt_t grp_cnt_s2 [cwhc_pkg::GROUPS];
	logic            row_end_s2;
	cwhc_pkg::count_t cnt_sum;

	assign out_load = valid_s2 && (!out_valid || out_ready);
	assign s2_free  = !valid_s2 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			grp_cnt_s2 <= grp_cnt;
			row_end_s2 <= row_end_s1;
		end
	end

	always_comb begin
		cnt_sum = '0;
		for (int g = 0; g < cwhc_pkg::GROUPS; g++) begin
			cnt_sum = cnt_sum + cwhc_pkg::WIN_W'(grp_cnt_s2[g]);
		end
	end

	// Output register: advance when empty or when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			window_count <= cnt_sum;
			row_done     <= row_end_s2;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASSERT_PROP(a_fwd_same_col, clk, arst_n,
		in_accept && s1_move && (col_s1 == col_cur) |=> fwd_s1,
		"write-back to the column being read was not forwarded")
	`ASSERT_PROP(a_row_end_restart, clk, arst_n,
		in_accept && row_end |=> (col_q == '0) && !first_q,
		"row end did not restart the column and leave the first row")
	`ASSERT_PROP(a_s2_hold, clk, arst_n,
		valid_s2 && !s2_free |=> valid_s2 && $stable(row_end_s2),
		"stage 2 dropped or changed a held transaction")
	`ASSERT_NEVER(a_count_range, clk, arst_n,
		out_valid && (window_count > cwhc_pkg::WIN_MAX),
		"window count exceeds the window limit")

endmodule

### hw/rtl/cwhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cwhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sim/cwhc_result_checker.sv
// Checker for the column window hit counter: predicts every result and compares it.
`timescale 1ns / 1ps

module cwhc_result_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             hit,
	input  logic             matrix_start,
	input  logic             row_end,
	input  logic             out_valid,
	input  logic             out_ready,
	input  cwhc_pkg::count_t window_count,
	input  logic             row_done,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  cwhc_pkg::count_t cfg_data,
	output int               fail_count,
	output int               pending,
	output int               results_checked
);

	typedef struct packed {
		cwhc_pkg::count_t window_count;
		logic             row_done;
	} cell_result_t;

	cell_result_t     expected_results[$];
	cell_result_t     want;
	cwhc_pkg::hist_t  column_bits[cwhc_pkg::MAX_COLUMNS];
	int unsigned      next_col    = 0;
	logic             first_row   = 1'b1;
	cwhc_pkg::count_t window_rows = cwhc_pkg::count_t'(1);
	int               fails       = 0;
	int               waiting     = 0;
	int               compared    = 0;

	assign fail_count      = fails;
	assign pending         = waiting;
	assign results_checked = compared;

	// Shift the cell into its column history and count the newest window bits.
	function automatic cell_result_t count_column(input logic cell_hit, input logic start,
			input logic closing);
		int unsigned      col;
		cwhc_pkg::hist_t  bits;
		cwhc_pkg::hist_t  mask;
		cwhc_pkg::count_t span;
		cell_result_t     r;
		if (start) begin
			next_col  = 0;
			first_row = 1'b1;
		end
		col  = next_col;
		bits = first_row ? '0 : column_bits[col];
		bits = {bits[cwhc_pkg::HIST_W-2:0], cell_hit};
		column_bits[col] = bits;
		span = (window_rows > cwhc_pkg::WIN_MAX) ? cwhc_pkg::WIN_MAX : window_rows;
		mask = (span >= cwhc_pkg::HIST_W) ? '1
			: ((cwhc_pkg::hist_t'(1) << span) - cwhc_pkg::hist_t'(1));
		r.window_count = cwhc_pkg::count_t'($countones(bits & mask));
		r.row_done     = closing;
		if (closing) begin
			next_col  = 0;
			first_row = 1'b0;
		end else begin
			next_col = (col + 1) % cwhc_pkg::MAX_COLUMNS;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			next_col    = 0;
			first_row   = 1'b1;
			window_rows = cwhc_pkg::count_t'(1);
			waiting     = 0;
		end else begin
			if (out_valid && out_ready) begin
				compared++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: window_count %0d, row_done %0b",
						window_count, row_done);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (window_count !== want.window_count) begin
						$error("window_count: expected %0d, actual %0d",
							want.window_count, window_count);
						fails++;
					end
					if (row_done !== want.row_done) begin
						$error("row_done: expected %0b, actual %0b", want.row_done, row_done);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				window_rows = cfg_data;
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					count_column(hit, matrix_start, row_end));
			waiting = expected_results.size();
		end
	end

endmodule

### sim/tb_column_window_hit_counter.sv
// Testbench top for the column window hit counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_column_window_hit_counter;

	localparam int PHASES      = 8;
	localparam int PHASE_CELLS = 45;
	localparam int HOLD_CYCLES = 60;
	localparam int GAP_PCT     = 14;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             hit;
	logic             matrix_start;
	logic             row_end;
	logic             out_valid;
	logic             out_ready;
	cwhc_pkg::count_t window_count;
	logic             row_done;
	logic             cfg_valid;
	logic             cfg_ready;
	cwhc_pkg::count_t cfg_data;

	int fail_count;
	int pending;
	int results_checked;

	// Mirror of the block's column position, so that a later row never reaches
	// a column that has not been written since reset.
	int unsigned gen_col       = 0;
	bit          gen_first     = 1'b1;
	int          max_written   = -1;
	int          cells_sent    = 0;
	int          settings_used = 0;
	bit          gaps_on       = 1'b1;
	bit          hold_req      = 1'b0;

	// Directed cells as {hit, matrix_start, row_end}.
	logic [2:0] directed_cells [24] = '{
		// rows of the matrix implied by reset, no matrix_start yet
		3'b100, 3'b000, 3'b101,
		3'b100, 3'b100, 3'b101,
		// a one-cell row that both opens a matrix and closes the row
		3'b111, 3'b001,
		// a four-wide matrix, then a short ragged row and a full one
		3'b110, 3'b100, 3'b000, 3'b101,
		3'b100, 3'b000, 3'b100, 3'b101,
		3'b100, 3'b101,
		3'b100, 3'b100, 3'b100, 3'b101,
		3'b010, 3'b001
	};

	always #10 clk = ~clk;

	column_window_hit_counter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hit          (hit),
		.matrix_start (matrix_start),
		.row_end      (row_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_count (window_count),
		.row_done     (row_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	cwhc_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.hit             (hit),
		.matrix_start    (matrix_start),
		.row_end         (row_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.window_count    (window_count),
		.row_done        (row_done),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// True when the cell about to be sent has to close its row: outside the
	// first row the next column would read a history never written since reset.
	function automatic bit must_close(input bit start);
		int unsigned col;
		int          top_col;
		col     = start ? 0 : gen_col;
		top_col = (int'(col) > max_written) ? int'(col) : max_written;
		if (start || gen_first)
			return 1'b0;
		return (col + 1 < cwhc_pkg::MAX_COLUMNS) && (int'(col + 1) > top_col);
	endfunction

	// Pick how dense the hits of a matrix are: empty, random, mostly set, full.
	function automatic int hit_bias();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 50;
			2: return 90;
			default: return 100;
		endcase
	endfunction

	// Offer one cell, with random idle cycles ahead of it, and hold it until taken.
	task automatic push_cell(input logic h, input logic s, input logic e);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		hit          = h;
		matrix_start = s;
		row_end      = e;
		in_valid     = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// advance the position mirror the same way the block does
		if (s) begin
			gen_col   = 0;
			gen_first = 1'b1;
		end
		if (int'(gen_col) > max_written)
			max_written = int'(gen_col);
		if (e) begin
			gen_col   = 0;
			gen_first = 1'b0;
		end else begin
			gen_col = (gen_col + 1) % cwhc_pkg::MAX_COLUMNS;
		end
		cells_sent++;
	endtask

	// Send a well-formed matrix; ragged rows after the first get random lengths.
	task automatic send_matrix(input int width, input int rows, input int hit_pct,
			input bit ragged);
		int len;
		bit opening;
		bit closing;
		for (int r = 0; r < rows; r++) begin
			len = (ragged && r > 0) ? $urandom_range(1, width + 3) : width;
			for (int c = 0; c < len; c++) begin
				opening = (r == 0 && c == 0);
				closing = (c == len - 1) || must_close(opening);
				push_cell($urandom_range(0, 99) < hit_pct, opening, closing);
				if (closing)
					break;
			end
		end
	endtask

	// Send loose cells: stray matrix starts and rows broken off at random.
	task automatic send_noise(input int count);
		bit opening;
		bit closing;
		for (int i = 0; i < count; i++) begin
			opening = $urandom_range(0, 99) < 6;
			closing = ($urandom_range(0, 99) < 20) || must_close(opening);
			push_cell(1'($urandom_range(0, 1)), opening, closing);
		end
	endtask

	// Drain the block, then write the window register while nothing is in flight.
	task automatic write_window(input cwhc_pkg::count_t rows);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// let the three pipeline stages settle before touching the register
		repeat (4) @(negedge clk);
		cfg_data  = rows;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	// Result side: random stalls, plus one long hold-off on request so the
	// pipeline fills and in_ready has to drop.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready = !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
		end
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		cwhc_pkg::count_t win;
		int               phase_end;
		int               pick;
		int               guard;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		hit          = 1'b0;
		matrix_start = 1'b0;
		row_end      = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed cells run with the window left at its reset value of one row.
		foreach (directed_cells[i])
			push_cell(directed_cells[i][2], directed_cells[i][1], directed_cells[i][0]);

		for (int p = 0; p < PHASES; p++) begin
			// full window, zero, saturating values, one row, random settings, then a window of three rows
			case (p)
				0: win = cwhc_pkg::WIN_MAX;
				1: win = '0;
				2: win = cwhc_pkg::count_t'(127);
				3: win = cwhc_pkg::count_t'(1);
				4: win = cwhc_pkg::WIN_MAX + cwhc_pkg::count_t'(1);
				5: win = cwhc_pkg::count_t'($urandom_range(2, cwhc_pkg::MAX_WINDOW - 1));
				6: win = cwhc_pkg::count_t'($urandom_range(0, 127));
				default: win = cwhc_pkg::count_t'(3);
			endcase
			write_window(win);
			// one phase runs with no idle cycles on either side
			gaps_on = (p != 2);
			// one phase stalls the result side while cells keep coming
			if (p == 4)
				hold_req = 1'b1;
			phase_end = cells_sent + PHASE_CELLS;
			while (cells_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 20)
					send_noise($urandom_range(4, 16));
				else if (pick < 40)
					// narrow and deep, so wide windows fill up
					send_matrix($urandom_range(1, 2), $urandom_range(20, 70), hit_bias(), 1'b0);
				else
					send_matrix($urandom_range(1, 12), $urandom_range(1, 8), hit_bias(),
						1'($urandom_range(0, 1)));
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		for (guard = 0; pending != 0 && guard < 10000; guard++)
			@(negedge clk);
		// watch a little longer for results nobody asked for
		repeat (8) @(negedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);

		$display("Summary: %0d cells sent under %0d window settings, %0d results compared.",
			cells_sent, settings_used, results_checked);
		$display("Summary: ragged rows, stray matrix starts, a %0d-cycle output hold, %s",
			HOLD_CYCLES, "a gap-free phase.");
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cwhc_pkg.sv
hw/rtl/cwhc_ram.sv
hw/rtl/column_window_hit_counter.sv
sim/cwhc_result_checker.sv
sim/tb_column_window_hit_counter.sv
